[hw/rtl/u16u8_pkg.sv]
package u16u8_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;

  // Byte order mark bytes: FF then FE is little-endian, FE then FF big-endian
  localparam logic [ByteW-1:0] BomFf = 8'hFF;
  localparam logic [ByteW-1:0] BomFe = 8'hFE;

  // UTF-8 encoding limits and prefixes
  localparam logic [UnitW-1:0] Max1Byte = 16'h007F;
  localparam logic [UnitW-1:0] Max2Byte = 16'h07FF;
  localparam logic [2:0]       Lead2Pfx = 3'b110;
  localparam logic [3:0]       Lead3Pfx = 4'b1110;
  localparam logic [1:0]       ContPfx  = 2'b10;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] utf8_byte;
    logic             last_of_run;
    logic             odd_length_error;
  } out_item_t;

  // Work handed from the front to the back: one code unit or one error marker
  typedef struct packed {
    logic             is_error;
    logic [UnitW-1:0] unit;
  } job_t;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_STREAM = 3'b100
  } phase_t;

endpackage

[hw/rtl/utf16_to_utf8_stream_unit.sv]
// UTF-16 to UTF-8 stream transcoder. Raw UTF-16 bytes enter one per
// transaction on the in_ channel; UTF-8 bytes leave one per transaction on
// the out_ channel, leading byte first, with last_of_run set on the final
// byte produced for a code unit. The first pair of a stream is checked for
// a byte order mark (FF FE little-endian, FE FF big-endian) that produces
// no output; any other first pair uses the byte order in cfg_wdata
// (1 = big-endian) and is converted as a character. Surrogates are encoded
// unit by unit. A stream that ends on an unpaired byte yields one result
// with utf8_byte zero and odd_length_error set. Rate: the front takes one
// byte per cycle while the job queue has room and drops in_ready while it
// holds QUEUE_DEPTH jobs; the back sends one output byte per cycle while
// out_ready allows, so a code unit holds the output port until all of its
// UTF-8 bytes have left, and sustained input rate is set by that single
// output port: a three-byte unit brings only two input bytes. The first
// byte of a code unit passes through a queue entry and then the output
// register before it is presented on the out_ channel. Write cfg only
// while idle.
module utf16_to_utf8_stream_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u16u8_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16u8_pkg::out_item_t out_data
);
  import u16u8_pkg::*;

  logic queue_full;
  logic job_push;
  job_t job_data;
  logic job_pop;
  logic head_valid;
  job_t head_data;

  // Front: pair bytes, detect the mark, queue code units and error markers
  u16u8_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (queue_full),
    .job_push   (job_push),
    .job_data   (job_data)
  );

  // Short queue decoupling byte intake from byte emission
  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (job_data),
    .full       (queue_full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Back: walk each code unit out as one to three UTF-8 bytes
  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (job_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[hw/rtl/u16u8_front.sv]
module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  u16u8_pkg::in_item_t in_data,
  input  logic                queue_full,
  output logic                job_push,
  output u16u8_pkg::job_t     job_data
);
  import u16u8_pkg::*;

  logic             default_be_r;
  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] held_r, held_nxt;
  logic             pending_r, pending_nxt;
  logic             mode_r, mode_nxt;
  logic             accept;
  logic             is_le_mark, is_be_mark;
  logic [UnitW-1:0] unit_be, unit_le;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  assign is_le_mark = (held_r == BomFf) && (in_data.in_byte == BomFe);
  assign is_be_mark = (held_r == BomFe) && (in_data.in_byte == BomFf);
  assign unit_be    = {held_r, in_data.in_byte};
  assign unit_le    = {in_data.in_byte, held_r};

  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    pending_nxt = pending_r;
    mode_nxt    = mode_r;
    job_push    = 1'b0;
    job_data    = '0;
    if (accept) begin
      if (!pending_r) begin
        held_nxt    = in_data.in_byte;
        pending_nxt = 1'b1;
        if (phase_r == PH_FIRST) begin
          phase_nxt = PH_SECOND;
        end
        if (in_data.end_of_stream) begin
          // unpaired final byte: drop it and flag the error
          job_push          = 1'b1;
          job_data.is_error = 1'b1;
          phase_nxt         = PH_FIRST;
          pending_nxt       = 1'b0;
        end
      end else begin
        pending_nxt = 1'b0;
        unique case (phase_r)
          PH_SECOND: begin
            phase_nxt = PH_STREAM;
            if (is_le_mark) begin
              mode_nxt = 1'b0;
            end else if (is_be_mark) begin
              mode_nxt = 1'b1;
            end else begin
              mode_nxt      = default_be_r;
              job_push      = 1'b1;
              job_data.unit = default_be_r ? unit_be : unit_le;
            end
          end
          default: begin
            job_push      = 1'b1;
            job_data.unit = mode_r ? unit_be : unit_le;
          end
        endcase
        if (in_data.end_of_stream) begin
          phase_nxt = PH_FIRST;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_be_r <= 1'b0;
      phase_r      <= PH_FIRST;
      pending_r    <= 1'b0;
      mode_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        default_be_r <= cfg_wdata;
      end
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
      mode_r    <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  // a held byte always belongs to a stream already under way
  a_pending_phase: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (phase_r != PH_FIRST))
    else $error("byte held while expecting the first byte");

  // an error job only comes from a final byte with nothing held
  a_error_src: assert property (@(posedge clk) disable iff (!rst_n)
    (job_push && job_data.is_error) |-> (!pending_r && in_data.end_of_stream))
    else $error("error job without an unpaired final byte");

endmodule

[hw/rtl/u16u8_queue.sv]
module u16u8_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::job_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output u16u8_pkg::job_t head_data
);
  import u16u8_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  job_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [CntW-1:0] count_r;

  assign full       = (count_r == FullCnt);
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == LastPtr) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == LastPtr) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid))
    else $error("job queue underflow");

endmodule

[hw/rtl/u16u8_back.sv]
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  u16u8_pkg::job_t      head_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16u8_pkg::out_item_t out_data
);
  import u16u8_pkg::*;

  logic [1:0]       idx_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic             slot_free;
  logic             load;
  logic [1:0]       last_idx;
  logic             is_last;
  logic [ByteW-1:0] cur_byte;
  logic [UnitW-1:0] u;

  assign u         = head_data.unit;
  assign slot_free = !out_valid_r || out_ready;
  assign load      = head_valid && slot_free;

  always_comb begin
    if (head_data.is_error || (u <= Max1Byte)) begin
      last_idx = 2'd0;
    end else if (u <= Max2Byte) begin
      last_idx = 2'd1;
    end else begin
      last_idx = 2'd2;
    end
  end

  assign is_last = (idx_r == last_idx);

  always_comb begin
    cur_byte = '0;
    if (!head_data.is_error) begin
      case (last_idx)
        2'd0: cur_byte = u[7:0];
        2'd1: cur_byte = (idx_r == 2'd0) ? {Lead2Pfx, u[10:6]} : {ContPfx, u[5:0]};
        default: begin
          case (idx_r)
            2'd0:    cur_byte = {Lead3Pfx, u[15:12]};
            2'd1:    cur_byte = {ContPfx, u[11:6]};
            default: cur_byte = {ContPfx, u[5:0]};
          endcase
        end
      endcase
    end
  end

  assign pop       = load && is_last;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= is_last ? 2'd0 : idx_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.utf8_byte        <= cur_byte;
      out_data_r.last_of_run      <= is_last;
      out_data_r.odd_length_error <= head_data.is_error;
    end
  end

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.odd_length_error) |->
      (out_data_r.last_of_run && (out_data_r.utf8_byte == '0)))
    else $error("error result must be a single zero byte");

endmodule

[tb/utf16_to_utf8_stream_unit_tb.sv]
module utf16_to_utf8_stream_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u16u8_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned LONG_HOLD   = 200;   // receiver back-pressure stretch, in cycles
  localparam int unsigned SETTLE      = 8;     // cycles allowed for a held byte to settle
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum int {MARK_NONE, MARK_LE, MARK_BE} mark_e;
  typedef enum int {END_ON_PAIR, END_ODD_BYTE, END_OPEN} ending_e;

  // Tracks the transcoder state and the UTF-8 bytes still owed by the block.
  class TranscodeTracker;
    out_item_t   owed_utf8[$];
    phase_t      stream_state;
    logic [7:0]  held;
    bit          held_valid;
    bit          big_mode;
    bit          default_big;
    int unsigned errors;

    function new();
      stream_state = PH_FIRST;
      held         = '0;
      held_valid   = 1'b0;
      big_mode     = 1'b0;
      default_big  = 1'b0;
      errors       = 0;
    endfunction

    function void set_default(bit be);
      default_big = be;
    endfunction

    function bit mid_stream();
      return (stream_state != PH_FIRST) || held_valid;
    endfunction

    function int unsigned outstanding();
      return owed_utf8.size();
    endfunction

    function void owe(logic [7:0] b, bit last, bit err);
      out_item_t r;
      r.utf8_byte        = b;
      r.last_of_run      = last;
      r.odd_length_error = err;
      owed_utf8.push_back(r);
    endfunction

    function void encode_code_unit(logic [15:0] u);
      if (u <= Max1Byte) begin
        owe(u[7:0], 1'b1, 1'b0);
      end else if (u <= Max2Byte) begin
        owe({Lead2Pfx, u[10:6]}, 1'b0, 1'b0);
        owe({ContPfx, u[5:0]}, 1'b1, 1'b0);
      end else begin
        owe({Lead3Pfx, u[15:12]}, 1'b0, 1'b0);
        owe({ContPfx, u[11:6]}, 1'b0, 1'b0);
        owe({ContPfx, u[5:0]}, 1'b1, 1'b0);
      end
    endfunction

    function void close_stream();
      stream_state = PH_FIRST;
      held_valid   = 1'b0;
      held         = '0;
    endfunction

    function void note_utf16_byte(in_item_t it);
      logic [7:0] first;
      if (!held_valid) begin
        held       = it.in_byte;
        held_valid = 1'b1;
        if (stream_state == PH_FIRST) stream_state = PH_SECOND;
        if (it.end_of_stream) begin
          owe('0, 1'b1, 1'b1);
          close_stream();
        end
        return;
      end
      first      = held;
      held_valid = 1'b0;
      if (stream_state == PH_SECOND) begin
        stream_state = PH_STREAM;
        if (first == BomFf && it.in_byte == BomFe) begin
          big_mode = 1'b0;
        end else if (first == BomFe && it.in_byte == BomFf) begin
          big_mode = 1'b1;
        end else begin
          big_mode = default_big;
          encode_code_unit(big_mode ? {first, it.in_byte} : {it.in_byte, first});
        end
      end else begin
        encode_code_unit(big_mode ? {first, it.in_byte} : {it.in_byte, first});
      end
      if (it.end_of_stream) close_stream();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endfunction

    function void check_utf8_byte(out_item_t got);
      out_item_t want;
      if (owed_utf8.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b err %0b",
                         got.utf8_byte, got.last_of_run, got.odd_length_error));
        return;
      end
      want = owed_utf8.pop_front();
      if (got.utf8_byte !== want.utf8_byte || got.last_of_run !== want.last_of_run ||
          got.odd_length_error !== want.odd_length_error)
        report($sformatf("expected %02h last %0b err %0b, got %02h last %0b err %0b",
                         want.utf8_byte, want.last_of_run, want.odd_length_error,
                         got.utf8_byte, got.last_of_run, got.odd_length_error));
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  TranscodeTracker sb = new();

  int unsigned items_sent   = 0;
  int unsigned snd_gap_max  = 0;
  int unsigned rcv_gap_max  = 0;
  bit          hold_request = 1'b0;

  utf16_to_utf8_stream_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 4 ns period: 2 ns high, 2 ns low
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Pick an idle ceiling for the next stretch: none at all, light, or heavy.
  function automatic int unsigned pick_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 16;
    endcase
  endfunction

  // Offer one byte as a transaction. Called at a rising edge; returns at the edge where
  // the transaction is accepted, leaving valid high so a back-to-back byte needs no
  // second assignment in that step.
  task automatic send_byte(input logic [7:0] b, input bit eos);
    in_item_t    it;
    int unsigned gap;
    it.in_byte       = b;
    it.end_of_stream = eos;
    if (items_sent % 24 == 0) snd_gap_max = pick_gap_max();
    gap = $urandom_range(0, snd_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_utf16_byte(it);
    items_sent++;
  endtask

  // Send a code unit as its two bytes in the stream's byte order; flag the second
  // byte as the end of stream when asked.
  task automatic send_unit(input logic [15:0] u, input bit big, input bit eos);
    send_byte(big ? u[15:8] : u[7:0], 1'b0);
    send_byte(big ? u[7:0] : u[15:8], eos);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every owed byte has arrived, then let any held byte settle.
  task automatic wait_idle();
    drop_valid();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_default(input bit be);
    cfg_we    <= 1'b1;
    cfg_wdata <= be;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_default(be);
  endtask

  // Bias code units towards the encoding boundaries and the surrogate range.
  function automatic logic [15:0] pick_unit();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hFFFF));
      3: return 16'($urandom_range(16'hD800, 16'hDFFF));
      4: begin
        case ($urandom_range(0, 7))
          0:       return 16'h0000;
          1:       return 16'h007F;
          2:       return 16'h0080;
          3:       return 16'h07FF;
          4:       return 16'h0800;
          5:       return 16'hFEFF;
          6:       return 16'hFFFE;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Mostly well-formed streams: an optional mark, a run of units in the matching byte
  // order, then a clean end, an odd trailing byte, or no end at all. One stream in ten
  // is raw noise with the end flag scattered about.
  task automatic send_random_stream();
    mark_e       mark;
    ending_e     ending;
    int unsigned units;
    bit          big;
    if ($urandom_range(0, 9) == 0) begin
      units = $urandom_range(1, 12);
      for (int i = 0; i < units; i++)
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    case ($urandom_range(0, 3))
      1:       mark = MARK_LE;
      2:       mark = MARK_BE;
      default: mark = MARK_NONE;
    endcase
    case ($urandom_range(0, 5))
      4:       ending = END_ODD_BYTE;
      5:       ending = END_OPEN;
      default: ending = END_ON_PAIR;
    endcase
    units = $urandom_range((mark == MARK_NONE) ? 1 : 0, 10);
    big   = (mark == MARK_BE) ? 1'b1 : (mark == MARK_LE) ? 1'b0 : sb.default_big;
    if (mark == MARK_LE) begin
      send_byte(BomFf, 1'b0);
      send_byte(BomFe, units == 0 && ending == END_ON_PAIR);
    end else if (mark == MARK_BE) begin
      send_byte(BomFe, 1'b0);
      send_byte(BomFf, units == 0 && ending == END_ON_PAIR);
    end
    for (int i = 0; i < units; i++)
      send_unit(pick_unit(), big, (i == units - 1) && ending == END_ON_PAIR);
    if (ending == END_ODD_BYTE) send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Run a random phase of roughly the given number of bytes. Optionally pause the
  // sender halfway until the block has delivered everything owed. Close any open
  // stream at the end so the next register write lands between streams.
  task automatic run_random(input int unsigned budget, input bit pause_midway);
    int unsigned start;
    bit          paused;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < budget) begin
      send_random_stream();
      if (pause_midway && !paused && items_sent - start >= budget / 2) begin
        paused = 1'b1;
        drop_valid();
        while (sb.outstanding() != 0) @(posedge clk);
      end
    end
    if (sb.mid_stream()) send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Result side: draw an idle gap per transaction, check every accepted byte against
  // the oldest owed one, and honour one long hold-off when the stimulus asks for it.
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 30 == 0) rcv_gap_max = pick_gap_max();
      gap = $urandom_range(0, rcv_gap_max);
      if (hold_request) begin
        hold_request = 1'b0;
        gap += LONG_HOLD;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_utf8_byte(out_data);
      taken++;
    end
  end

  // Watchdog: count cycles and abandon a run that hangs.
  initial begin : watchdog
    int unsigned cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Little-endian default, written explicitly.
    write_default(1'b0);

    // No mark: the first pair is a character in the default order. Walk the
    // one/two/three byte boundaries and finish on a lone surrogate.
    send_byte(8'h41, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h07, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h08, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'hD8, 1'b1);
    // Little-endian mark, then the smallest and largest single-byte units.
    send_byte(BomFf, 1'b0); send_byte(BomFe, 1'b0);
    send_byte(8'h7F, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b1);
    // Big-endian mark, one unit, then an odd trailing byte that ends the stream.
    send_byte(BomFe, 1'b0); send_byte(BomFf, 1'b0);
    send_byte(8'h12, 1'b0); send_byte(8'h34, 1'b0);
    send_byte(8'hAB, 1'b1);
    // A stream of one byte, and a stream that is nothing but a mark.
    send_byte(8'h5A, 1'b1);
    send_byte(BomFe, 1'b0); send_byte(BomFf, 1'b1);
    wait_idle();

    // Big-endian default: no mark, first pair read high byte first.
    write_default(1'b1);
    send_byte(8'h00, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'h07, 1'b0); send_byte(8'hFF, 1'b1);
    run_random(85, 1'b0);
    wait_idle();

    // Back to little-endian; stall the receiver for a long stretch so the block
    // fills and pushes back on its input while the sender keeps offering.
    write_default(1'b0);
    hold_request = 1'b1;
    run_random(95, 1'b0);
    wait_idle();

    // Big-endian again, with the sender pausing halfway until the output drains.
    write_default(1'b1);
    run_random(95, 1'b1);

    // Drain, then keep watching for any stray result before the verdict.
    drop_valid();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/u16u8_pkg.sv
hw/rtl/u16u8_front.sv
hw/rtl/u16u8_queue.sv
hw/rtl/u16u8_back.sv
hw/rtl/utf16_to_utf8_stream_unit.sv
tb/utf16_to_utf8_stream_unit_tb.sv
